>>> hw/rtl/cfa_pkg.sv
// Package for the contiguous frame allocator.
// Holds widths, operation, status and frame state codes, payload structs and
// the control/status structs shared by the controller and the datapath.
package cfa_pkg;

  localparam int unsigned FRAME_W        = 20;
  localparam int unsigned CNT_W          = 11;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CFG_DATA_W     = 20;
  localparam int unsigned MAX_FRAMES_DEF = 1024;
  localparam int unsigned RST_POOL       = 1024;

  typedef enum logic [1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_MARK    = 2'd2,
    OP_REINIT  = 2'd3
  } op_kind_e;

  typedef enum logic [2:0] {
    STS_OK      = 3'd0,
    STS_FEW     = 3'd1,
    STS_NORUN   = 3'd2,
    STS_NOTHEAD = 3'd3,
    STS_RANGE   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    FS_FREE = 2'd0,
    FS_USED = 2'd1,
    FS_HEAD = 2'd2
  } frame_state_e;

  typedef enum logic [1:0] {
    REG_BASE_FRAME    = 2'd0,
    REG_POOL_FRAMES   = 2'd1,
    REG_RESERVE_FIRST = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    DP_IDLE,
    DP_LOAD,
    DP_SCAN,
    DP_FILL,
    DP_REL,
    DP_MARK,
    DP_CLEAR
  } dp_cmd_e;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SCAN,
    S_FILL,
    S_REL,
    S_MARK,
    S_CLEAR
  } ctrl_state_e;

  typedef struct packed {
    op_kind_e           kind;
    logic [FRAME_W-1:0] frame_no;
    logic [CNT_W-1:0]   run_length;
  } item_t;

  typedef struct packed {
    status_e            status;
    logic [FRAME_W-1:0] first_frame;
    logic [CNT_W-1:0]   free_frames;
  } result_t;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    emit;
    status_e status;
    logic    ret_first;
  } ctl_t;

  typedef struct packed {
    op_kind_e kind;
    logic     too_few;
    logic     zero_len;
    logic     out_of_range;
    logic     found;
    logic     scan_end;
    logic     fill_last;
    logic     not_head;
    logic     rel_end;
    logic     mark_last;
    logic     clear_last;
  } sts_t;

endpackage

>>> hw/rtl/cfa_dpath.sv
// Datapath of the contiguous frame allocator: configuration registers,
// frame state memory, scan pointers, free counter and result register.
// Depends on cfa_pkg; driven by cfa_ctrl through ctl_t, reports through sts_t.
module cfa_dpath #(
  parameter int unsigned MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  cfa_pkg::item_t                 item_i,
  input  cfa_pkg::ctl_t                  ctl_i,
  output cfa_pkg::sts_t                  sts_o,
  output logic                           done_o,
  output cfa_pkg::result_t               result_o
);

  localparam int unsigned AW  = $clog2(MAX_FRAMES);
  localparam int unsigned CW  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned NW  = cfa_pkg::CNT_W;
  localparam int unsigned FW  = cfa_pkg::FRAME_W;
  localparam int unsigned RST_N =
    (MAX_FRAMES < cfa_pkg::RST_POOL) ? MAX_FRAMES : cfa_pkg::RST_POOL;

  logic [FW-1:0] base_q;
  logic [NW-1:0] pool_q;
  logic          rsv_q;

  cfa_pkg::frame_state_e mem [MAX_FRAMES];
  cfa_pkg::frame_state_e rd_q;
  logic                  we;
  logic [AW-1:0]         waddr;
  cfa_pkg::frame_state_e wdata;

  logic [CW-1:0] rptr_q, rptr_d;
  logic [CW-1:0] wptr_q, wptr_d;
  logic [CW-1:0] rd_idx_q;
  logic          rd_vld_q;
  logic [CW-1:0] start_q, start_d;
  logic [NW-1:0] run_q, run_d;
  logic [NW-1:0] cnt_q, cnt_d;
  logic [NW-1:0] len_q, len_d;
  logic          hd_q, hd_d;
  logic          clr_head_q, clr_head_d;
  logic [NW-1:0] free_q, free_d;
  logic          done_q;
  cfa_pkg::result_t res_q;

  logic [NW-1:0] n11;
  logic [CW-1:0] n_ix;
  logic [FW-1:0] diff;
  logic [CW-1:0] rel_ix;
  logic          issue;
  logic          rd_free;
  logic [NW-1:0] run_n;
  logic [CW-1:0] start_n;
  logic [NW-1:0] free_dec;
  logic [NW-1:0] free_inc;
  logic          rel_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      pool_q <= NW'(cfa_pkg::RST_POOL);
      rsv_q  <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cfa_pkg::REG_BASE_FRAME:    base_q <= cfg_wdata_i[FW-1:0];
        cfa_pkg::REG_POOL_FRAMES:   pool_q <= cfg_wdata_i[NW-1:0];
        cfa_pkg::REG_RESERVE_FIRST: rsv_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (pool_q == '0) begin
      n11 = NW'(1);
    end else if (32'(pool_q) > 32'(MAX_FRAMES)) begin
      n11 = NW'(MAX_FRAMES);
    end else begin
      n11 = pool_q;
    end
    n_ix = CW'(n11);
  end

  assign diff   = item_i.frame_no - base_q;
  assign rel_ix = CW'(diff);

  assign rd_free  = (rd_q == cfa_pkg::FS_FREE);
  assign run_n    = rd_free ? run_q + NW'(1) : '0;
  assign start_n  = (rd_free && run_q == '0) ? rd_idx_q : start_q;
  assign issue    = ((ctl_i.cmd == cfa_pkg::DP_SCAN) || (ctl_i.cmd == cfa_pkg::DP_REL))
                    && (rptr_q < n_ix);
  assign free_dec = (free_q == '0) ? '0 : free_q - NW'(1);
  assign free_inc = (free_q < n11) ? free_q + NW'(1) : free_q;
  assign rel_take = rd_vld_q && (hd_q ? (rd_q == cfa_pkg::FS_HEAD)
                                      : (rd_q == cfa_pkg::FS_USED));

  always_comb begin
    sts_o.kind         = item_i.kind;
    sts_o.too_few      = item_i.run_length > free_q;
    sts_o.zero_len     = item_i.run_length == '0;
    sts_o.out_of_range = (item_i.frame_no < base_q) || ({1'b0, diff} >= (FW + 1)'(n11));
    sts_o.found        = rd_vld_q && rd_free && (run_n == len_q);
    sts_o.scan_end     = !rd_vld_q && (rptr_q >= n_ix);
    sts_o.fill_last    = ({1'b0, cnt_q} + (NW + 1)'(1)) == {1'b0, len_q};
    sts_o.not_head     = rd_vld_q && hd_q && (rd_q != cfa_pkg::FS_HEAD);
    sts_o.rel_end      = (rd_vld_q && !hd_q && (rd_q != cfa_pkg::FS_USED))
                         || (!rd_vld_q && (rptr_q >= n_ix));
    sts_o.mark_last    = !(({1'b0, cnt_q} + (NW + 1)'(1)) < {1'b0, len_q})
                         || !(({1'b0, wptr_q} + (CW + 1)'(1)) < {1'b0, n_ix});
    sts_o.clear_last   = wptr_q == CW'(MAX_FRAMES - 1);
  end

  always_comb begin
    rptr_d     = rptr_q;
    wptr_d     = wptr_q;
    start_d    = start_q;
    run_d      = run_q;
    cnt_d      = cnt_q;
    len_d      = len_q;
    hd_d       = hd_q;
    clr_head_d = clr_head_q;
    free_d     = free_q;
    we         = 1'b0;
    waddr      = wptr_q[AW-1:0];
    wdata      = cfa_pkg::FS_FREE;
    unique case (ctl_i.cmd)
      cfa_pkg::DP_LOAD: begin
        run_d = '0;
        cnt_d = '0;
        hd_d  = 1'b1;
        len_d = item_i.run_length;
        rptr_d = (item_i.kind == cfa_pkg::OP_ALLOC) ? '0 : rel_ix;
        wptr_d = (item_i.kind == cfa_pkg::OP_REINIT) ? '0 : rel_ix;
        if (item_i.kind == cfa_pkg::OP_REINIT) begin
          free_d     = n11 - NW'(rsv_q);
          clr_head_d = rsv_q;
        end
      end
      cfa_pkg::DP_SCAN: begin
        rptr_d = rptr_q + CW'(issue);
        if (rd_vld_q) begin
          run_d   = run_n;
          start_d = start_n;
          if (sts_o.found) begin
            wptr_d = start_n;
            cnt_d  = '0;
          end
        end
      end
      cfa_pkg::DP_FILL: begin
        we     = 1'b1;
        wdata  = (cnt_q == '0) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
        wptr_d = wptr_q + CW'(1);
        cnt_d  = cnt_q + NW'(1);
        free_d = free_dec;
      end
      cfa_pkg::DP_REL: begin
        rptr_d = rptr_q + CW'(issue);
        if (rd_vld_q) begin
          hd_d = 1'b0;
        end
        if (rel_take) begin
          we     = 1'b1;
          waddr  = rd_idx_q[AW-1:0];
          wdata  = cfa_pkg::FS_FREE;
          free_d = free_inc;
        end
      end
      cfa_pkg::DP_MARK: begin
        we     = 1'b1;
        wdata  = (cnt_q == '0) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_USED;
        wptr_d = wptr_q + CW'(1);
        cnt_d  = cnt_q + NW'(1);
        free_d = free_dec;
      end
      cfa_pkg::DP_CLEAR: begin
        we     = 1'b1;
        wdata  = (wptr_q == '0 && clr_head_q) ? cfa_pkg::FS_HEAD : cfa_pkg::FS_FREE;
        wptr_d = wptr_q + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[rptr_q[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rptr_q     <= '0;
      wptr_q     <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      start_q    <= '0;
      run_q      <= '0;
      cnt_q      <= '0;
      len_q      <= '0;
      hd_q       <= 1'b0;
      clr_head_q <= 1'b1;
      free_q     <= NW'(RST_N - 1);
      done_q     <= 1'b0;
    end else begin
      rptr_q     <= rptr_d;
      wptr_q     <= wptr_d;
      rd_idx_q   <= rptr_q;
      rd_vld_q   <= issue;
      start_q    <= start_d;
      run_q      <= run_d;
      cnt_q      <= cnt_d;
      len_q      <= len_d;
      hd_q       <= hd_d;
      clr_head_q <= clr_head_d;
      free_q     <= free_d;
      done_q     <= ctl_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.emit) begin
      res_q.status      <= ctl_i.status;
      res_q.first_frame <= ctl_i.ret_first ? base_q + FW'(start_q) : '0;
      res_q.free_frames <= free_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> hw/rtl/cfa_ctrl.sv
// Controller of the contiguous frame allocator: sequences the operations.
// Depends on cfa_pkg; commands cfa_dpath through ctl_t, reads sts_t back.
module cfa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  cfa_pkg::sts_t sts_i,
  output cfa_pkg::ctl_t ctl_o,
  output logic          busy
);

  cfa_pkg::ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cfa_pkg::S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    ctl_o.cmd       = cfa_pkg::DP_IDLE;
    ctl_o.emit      = 1'b0;
    ctl_o.status    = cfa_pkg::STS_OK;
    ctl_o.ret_first = 1'b0;
    busy            = 1'b1;
    unique case (state_q)
      cfa_pkg::S_INIT: begin
        ctl_o.cmd = cfa_pkg::DP_CLEAR;
        if (sts_i.clear_last) begin
          state_d = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctl_o.cmd = cfa_pkg::DP_LOAD;
          unique case (sts_i.kind)
            cfa_pkg::OP_ALLOC: begin
              priority if (sts_i.too_few) begin
                ctl_o.emit   = 1'b1;
                ctl_o.status = cfa_pkg::STS_FEW;
              end else if (sts_i.zero_len) begin
                ctl_o.emit   = 1'b1;
                ctl_o.status = cfa_pkg::STS_NORUN;
              end else begin
                state_d = cfa_pkg::S_SCAN;
              end
            end
            cfa_pkg::OP_RELEASE: begin
              if (sts_i.out_of_range) begin
                ctl_o.emit   = 1'b1;
                ctl_o.status = cfa_pkg::STS_RANGE;
              end else begin
                state_d = cfa_pkg::S_REL;
              end
            end
            cfa_pkg::OP_MARK: begin
              if (sts_i.out_of_range) begin
                ctl_o.emit   = 1'b1;
                ctl_o.status = cfa_pkg::STS_RANGE;
              end else begin
                state_d = cfa_pkg::S_MARK;
              end
            end
            cfa_pkg::OP_REINIT: begin
              state_d = cfa_pkg::S_CLEAR;
            end
            default: ;
          endcase
        end
      end
      cfa_pkg::S_SCAN: begin
        ctl_o.cmd = cfa_pkg::DP_SCAN;
        priority if (sts_i.found) begin
          state_d = cfa_pkg::S_FILL;
        end else if (sts_i.scan_end) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = cfa_pkg::STS_NORUN;
          state_d      = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_FILL: begin
        ctl_o.cmd = cfa_pkg::DP_FILL;
        if (sts_i.fill_last) begin
          ctl_o.emit      = 1'b1;
          ctl_o.ret_first = 1'b1;
          state_d         = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_REL: begin
        ctl_o.cmd = cfa_pkg::DP_REL;
        priority if (sts_i.not_head) begin
          ctl_o.emit   = 1'b1;
          ctl_o.status = cfa_pkg::STS_NOTHEAD;
          state_d      = cfa_pkg::S_IDLE;
        end else if (sts_i.rel_end) begin
          ctl_o.emit = 1'b1;
          state_d    = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_MARK: begin
        ctl_o.cmd = cfa_pkg::DP_MARK;
        if (sts_i.mark_last) begin
          ctl_o.emit = 1'b1;
          state_d    = cfa_pkg::S_IDLE;
        end
      end
      cfa_pkg::S_CLEAR: begin
        ctl_o.cmd = cfa_pkg::DP_CLEAR;
        if (sts_i.clear_last) begin
          ctl_o.emit = 1'b1;
          state_d    = cfa_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = cfa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

>>> hw/rtl/contiguous_frame_allocator_unit.sv
// Top level of the contiguous frame allocator.
// Depends on cfa_pkg; instantiates cfa_ctrl and cfa_dpath.
//
// A command is taken when start is high and busy is low; its single result
// shows on result_o for exactly one cycle with done_o high and cannot be held
// off, so the receiver must take it then. The frame state store has one read
// and one write port and is walked one entry per cycle. A rejected command (too
// few free, zero length, out of range) is answered without touching the store;
// an allocate scans the pool for a run and then fills it, or answers when the
// scan ends with no run; release walks from the head until the run ends, and
// answers on its first read when the frame is not a head; mark writes at least
// one frame; reinitialize clears all MAX_FRAMES entries. busy is low again in
// the cycle the result shows, so the next command can be taken then. After
// reset the store is cleared with busy high; configuration writes are taken
// at any time but are meant to be made while idle.
module contiguous_frame_allocator_unit #(
  parameter int unsigned MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  cfa_pkg::item_t                 item_i,
  output logic                           done_o,
  output cfa_pkg::result_t               result_o,
  input  logic                           cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);

  cfa_pkg::ctl_t ctl;
  cfa_pkg::sts_t sts;

  cfa_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .ctl_o  (ctl),
    .busy   (busy)
  );

  cfa_dpath #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .item_i      (item_i),
    .ctl_i       (ctl),
    .sts_o       (sts),
    .done_o      (done_o),
    .result_o    (result_o)
  );

endmodule

>>> tb/cfa_reply_checker.sv
// Reply checker for the contiguous frame allocator.
// Keeps its own copy of the frame pool and predicts the reply to every accepted command.
// Depends on cfa_pkg for the payload structs and codes.
module cfa_reply_checker #(
  parameter int unsigned MAX_FRAMES = cfa_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic                           busy_i,
  input  cfa_pkg::item_t                 item_i,
  input  logic                           done_i,
  input  cfa_pkg::result_t               result_i,
  input  logic                           cfg_we_i,
  input  logic [cfa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [cfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int unsigned                    replies_due_o,
  output int unsigned                    mismatches_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  logic [FRAME_W-1:0] base_q;
  logic [CNT_W-1:0]   pool_reg_q;
  logic               reserve_q;
  frame_state_e       frames_q [MAX_FRAMES];
  int unsigned        free_cnt;
  result_t            due_replies [$];

  function automatic int unsigned pool_len();
    int unsigned n;
    n = 32'(pool_reg_q);
    if (n == 0) n = 1;
    if (n > MAX_FRAMES) n = MAX_FRAMES;
    return n;
  endfunction

  task automatic clear_pool();
    foreach (frames_q[k]) frames_q[k] = FS_FREE;
    if (reserve_q) begin
      frames_q[0] = FS_HEAD;
      free_cnt = pool_len() - 1;
    end else begin
      free_cnt = pool_len();
    end
  endtask

  task automatic take_frame();
    if (free_cnt > 0) free_cnt--;
  endtask

  task automatic give_frame();
    if (free_cnt < pool_len()) free_cnt++;
  endtask

  task automatic next_pool_reply(input item_t it, output result_t r);
    int unsigned n, run, head, rel, len, i;
    bit          found;
    bit          inside_pool;
    n = pool_len();
    len = 32'(it.run_length);
    r.status = STS_OK;
    r.first_frame = '0;
    rel = 32'(it.frame_no - base_q);
    inside_pool = (it.frame_no >= base_q) && (rel < n);
    case (it.kind)
      OP_ALLOC: begin
        if (len > free_cnt) begin
          r.status = STS_FEW;
        end else if (len == 0) begin
          r.status = STS_NORUN;
        end else begin
          run = 0;
          head = 0;
          found = 0;
          for (i = 0; i < n; i++) begin
            if (frames_q[i] == FS_FREE) begin
              if (run == 0) head = i;
              run++;
              if (run == len) begin
                found = 1;
                break;
              end
            end else begin
              run = 0;
            end
          end
          if (!found) begin
            r.status = STS_NORUN;
          end else begin
            frames_q[head] = FS_HEAD;
            take_frame();
            for (i = 1; i < len; i++) begin
              frames_q[head + i] = FS_USED;
              take_frame();
            end
            r.first_frame = FRAME_W'(base_q + head);
          end
        end
      end
      OP_RELEASE: begin
        if (!inside_pool) begin
          r.status = STS_RANGE;
        end else if (frames_q[rel] != FS_HEAD) begin
          r.status = STS_NOTHEAD;
        end else begin
          frames_q[rel] = FS_FREE;
          give_frame();
          for (i = rel + 1; i < n && frames_q[i] == FS_USED; i++) begin
            frames_q[i] = FS_FREE;
            give_frame();
          end
        end
      end
      OP_MARK: begin
        if (!inside_pool) begin
          r.status = STS_RANGE;
        end else begin
          frames_q[rel] = FS_HEAD;
          take_frame();
          for (i = 1; i < len && rel + i < n; i++) begin
            frames_q[rel + i] = FS_USED;
            take_frame();
          end
        end
      end
      default: clear_pool();
    endcase
    r.free_frames = CNT_W'(free_cnt);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    result_t got;
    if (!rst_ni) begin
      base_q = '0;
      pool_reg_q = CNT_W'(RST_POOL);
      reserve_q = 1'b1;
      clear_pool();
      due_replies.delete();
      mismatches_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_BASE_FRAME:    base_q = cfg_wdata_i[FRAME_W-1:0];
          REG_POOL_FRAMES:   pool_reg_q = cfg_wdata_i[CNT_W-1:0];
          REG_RESERVE_FIRST: reserve_q = cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (done_i) begin
        got = result_i;
        if (due_replies.size() == 0) begin
          $display("%0t: reply with none due: expected no reply, got status %0d first %0h free %0d",
                   $time, got.status, got.first_frame, got.free_frames);
          mismatches_o++;
        end else begin
          want = due_replies.pop_front();
          if (got.status != want.status) begin
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
            mismatches_o++;
          end
          if (got.first_frame != want.first_frame) begin
            $display("%0t: first_frame mismatch: expected %0h, got %0h",
                     $time, want.first_frame, got.first_frame);
            mismatches_o++;
          end
          if (got.free_frames != want.free_frames) begin
            $display("%0t: free_frames mismatch: expected %0d, got %0d",
                     $time, want.free_frames, got.free_frames);
            mismatches_o++;
          end
        end
      end
      if (start_i && !busy_i) begin
        next_pool_reply(item_i, want);
        due_replies.push_back(want);
      end
    end
    replies_due_o = due_replies.size();
  end

endmodule

>>> tb/contiguous_frame_allocator_unit_tb.sv
// Testbench top for the contiguous frame allocator.
// Drives commands and register writes, and gives the verdict from cfa_reply_checker.
// Depends on cfa_pkg, contiguous_frame_allocator_unit and cfa_reply_checker.
module contiguous_frame_allocator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfa_pkg::*;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  start;
  logic                  busy;
  item_t                 item_i;
  logic                  done_o;
  result_t               result_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int unsigned           replies_due;
  int unsigned           mismatches;

  item_t                 issued_q [$];
  logic [FRAME_W-1:0]    live_heads [$];
  logic [FRAME_W-1:0]    cur_base;
  int unsigned           cur_n;
  bit                    burst;

  contiguous_frame_allocator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  cfa_reply_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start),
    .busy_i        (busy),
    .item_i        (item_i),
    .done_i        (done_o),
    .result_i      (result_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .replies_due_o (replies_due),
    .mismatches_o  (mismatches)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #200_000_000;
    $display("status: fail");
    $finish;
  end

  // heads handed out by the block, used to build valid releases
  always @(posedge clk_i) begin
    item_t op;
    if (done_o && issued_q.size() != 0) begin
      op = issued_q.pop_front();
      if (result_o.status == STS_OK) begin
        if (op.kind == OP_ALLOC) live_heads.push_back(result_o.first_frame);
        else if (op.kind == OP_MARK) live_heads.push_back(op.frame_no);
      end
    end
  end

  function automatic item_t mk(op_kind_e k, logic [FRAME_W-1:0] fno, logic [CNT_W-1:0] len);
    item_t it;
    it.kind = k;
    it.frame_no = fno;
    it.run_length = len;
    return it;
  endfunction

  task automatic wait_idle();
    do @(negedge clk_i); while (replies_due != 0 || busy);
  endtask

  // entered and left at a falling edge
  task automatic send(input item_t it);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 13);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    issued_q.push_back(it);
    @(negedge clk_i);
  endtask

  task automatic set_pool(input logic [FRAME_W-1:0] b, input logic [CNT_W-1:0] p,
                          input logic r);
    start <= 1'b0;
    wait_idle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BASE_FRAME;
    cfg_wdata_i <= b;
    @(negedge clk_i);
    cfg_idx_i <= REG_POOL_FRAMES;
    cfg_wdata_i <= CFG_DATA_W'(p);
    @(negedge clk_i);
    cfg_idx_i <= REG_RESERVE_FIRST;
    cfg_wdata_i <= CFG_DATA_W'(r);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    cur_base = b;
    cur_n = (p == '0) ? 1 : (32'(p) > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : 32'(p);
    live_heads.delete();
  endtask

  task automatic pick_op(output item_t it);
    int unsigned roll, sel, idx;
    roll = $urandom_range(0, 99);
    sel = $urandom_range(0, 99);
    it.frame_no = FRAME_W'($urandom);
    it.run_length = CNT_W'($urandom_range(1, 8));
    if (roll < 50) begin
      it.kind = OP_ALLOC;
      if (sel < 5) it.run_length = '0;
      else if (sel < 20) it.run_length = CNT_W'($urandom_range(1, cur_n));
      else if (sel < 30) it.run_length = CNT_W'($urandom);
    end else if (roll < 85) begin
      it.kind = OP_RELEASE;
      if (sel < 65 && live_heads.size() != 0) begin
        idx = $urandom_range(0, live_heads.size() - 1);
        it.frame_no = live_heads[idx];
        live_heads.delete(idx);
      end else if (sel < 85) begin
        it.frame_no = FRAME_W'(cur_base + $urandom_range(0, cur_n - 1));
      end
    end else if (roll < 97) begin
      it.kind = OP_MARK;
      if (sel < 80) it.frame_no = FRAME_W'(cur_base + $urandom_range(0, cur_n - 1));
      if (sel % 4 == 0) it.run_length = CNT_W'($urandom_range(0, cur_n + 8));
      else it.run_length = CNT_W'($urandom_range(0, 4));
    end else begin
      it.kind = OP_REINIT;
      live_heads.delete();
    end
  endtask

  initial begin
    item_t it;
    int unsigned pool_pick;
    start = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_wdata_i = '0;
    rst_ni = 1'b0;
    burst = 1'b0;
    cur_base = '0;
    cur_n = RST_POOL;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    // reset pool: base 0, 1024 frames, frame 0 reserved
    send(mk(OP_ALLOC, 0, 0));
    send(mk(OP_ALLOC, 0, 1024));
    send(mk(OP_ALLOC, 0, 2047));
    send(mk(OP_ALLOC, 0, 1023));
    send(mk(OP_ALLOC, 0, 1));
    send(mk(OP_RELEASE, 0, 0));
    send(mk(OP_RELEASE, 1, 0));
    send(mk(OP_RELEASE, 5, 0));
    send(mk(OP_RELEASE, 1024, 0));
    send(mk(OP_RELEASE, 20'hFFFFF, 0));
    send(mk(OP_MARK, 1020, 10));
    send(mk(OP_MARK, 3, 0));
    send(mk(OP_ALLOC, 0, 4));
    send(mk(OP_MARK, 3, 2));
    send(mk(OP_RELEASE, 3, 0));
    send(mk(OP_REINIT, 0, 0));
    send(mk(OP_MARK, 0, 1024));
    send(mk(OP_ALLOC, 0, 1));
    send(mk(OP_MARK, 20'hFFFFF, 2047));

    // top base with wrap, pool size above the maximum, no reserved frame
    set_pool(20'hFFFFF, 11'd2047, 1'b0);
    send(mk(OP_REINIT, 0, 0));
    send(mk(OP_ALLOC, 0, 1024));
    send(mk(OP_ALLOC, 0, 1));
    send(mk(OP_RELEASE, 20'hFFFFF, 0));
    send(mk(OP_RELEASE, 0, 0));
    send(mk(OP_MARK, 20'hFFFFF, 3));

    // pool size zero acts as one frame
    set_pool(20'h80000, 11'd0, 1'b1);
    send(mk(OP_REINIT, 0, 0));
    send(mk(OP_ALLOC, 0, 1));
    set_pool(20'h80000, 11'd0, 1'b0);
    send(mk(OP_REINIT, 0, 0));
    send(mk(OP_ALLOC, 0, 2));
    send(mk(OP_ALLOC, 0, 1));
    send(mk(OP_RELEASE, 20'h80000, 0));

    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 2 || ph == 6) pool_pick = $urandom_range(900, 1024);
      else if (ph == 4) pool_pick = $urandom_range(1, 4);
      else pool_pick = $urandom_range(8, 64);
      if (ph == 3) begin
        set_pool(FRAME_W'(20'hFFFFF - $urandom_range(0, 16)), CNT_W'(pool_pick),
                 1'($urandom_range(0, 1)));
      end else begin
        set_pool(FRAME_W'($urandom), CNT_W'(pool_pick), 1'($urandom_range(0, 1)));
      end
      burst = ($urandom_range(0, 3) == 0);
      send(mk(OP_REINIT, 0, 0));
      for (int k = 0; k < 50; k++) begin
        pick_op(it);
        send(it);
      end
      burst = 1'b0;
    end

    start <= 1'b0;
    wait_idle();
    repeat (20) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
